>>> rtl/core/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on clk, masked while arst_n is low.
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Implication check on clk, masked while arst_n is low.
`define ASSERT_IMPL(label, ante, cons, msg) \
	`ASSERT_CLK(label, (ante) |-> (cons), msg)

`endif

>>> rtl/core/lsbu_pkg.sv
package lsbu_pkg;

	localparam int BUCKETS_LOG2 = 10;
	localparam int KEY_BITS     = 64;

	localparam int BUCKET_W = 10;
	localparam int KEY_W    = 64;
	localparam int COUNT_W  = 31;

	localparam logic [KEY_W-1:0]   KEY_MASK  = {KEY_W{1'b1}} >> (KEY_W - KEY_BITS);
	localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

	typedef enum logic [1:0] {
		KIND_UPDATE,
		KIND_MERGE,
		KIND_HOLD
	} lsbu_kind_t;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LOOK
	} lsbu_state_t;

	typedef struct packed {
		logic                opcode;
		logic [BUCKET_W-1:0] bucket;
		logic [KEY_W-1:0]    key;
		logic [COUNT_W-1:0]  other_count;
		logic                other_occupied;
	} lsbu_in_t;

	typedef struct packed {
		logic [BUCKET_W-1:0] out_bucket;
		logic [KEY_W-1:0]    out_key;
		logic [COUNT_W-1:0]  out_count;
		logic                out_occupied;
		logic                key_replaced;
	} lsbu_out_t;

	typedef struct packed {
		lsbu_kind_t              kind;
		logic [BUCKETS_LOG2-1:0] addr;
		logic [KEY_W-1:0]        key;
		logic [COUNT_W-1:0]      other_count;
	} lsbu_op_t;

	typedef struct packed {
		logic               occupied;
		logic [KEY_W-1:0]   key;
		logic [COUNT_W-1:0] count;
	} lsbu_entry_t;

endpackage

>>> rtl/core/lsbu_front.sv
module lsbu_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  lsbu_pkg::lsbu_in_t item,
	input  logic              hold,
	output logic              op_valid,
	input  logic              op_pop,
	output lsbu_pkg::lsbu_op_t op
);

	logic [1:0]         cnt_q;
	logic               wr_q;
	logic               rd_q;
	lsbu_pkg::lsbu_op_t slot_q [2];
	lsbu_pkg::lsbu_op_t cls;
	logic               accept;

	assign full     = hold || (cnt_q == 2'd2);
	assign accept   = push && !full;
	assign op_valid = (cnt_q != 2'd0);
	assign op       = slot_q[rd_q];

	always_comb begin
		if (!item.opcode)
			cls.kind = lsbu_pkg::KIND_UPDATE;
		else if (item.other_occupied)
			cls.kind = lsbu_pkg::KIND_MERGE;
		else
			cls.kind = lsbu_pkg::KIND_HOLD;
		cls.addr        = item.bucket[lsbu_pkg::BUCKETS_LOG2-1:0];
		cls.key         = item.key & lsbu_pkg::KEY_MASK;
		cls.other_count = item.other_count;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
		end else begin
			cnt_q <= cnt_q + 2'(accept) - 2'(op_pop);
			if (accept)
				wr_q <= !wr_q;
			if (op_pop)
				rd_q <= !rd_q;
		end
	end

	always_ff @(posedge clk) begin
		if (accept)
			slot_q[wr_q] <= cls;
	end

endmodule

>>> rtl/core/lsbu_back.sv
`include "assert_macros.svh"

module lsbu_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               op_valid,
	output logic               op_pop,
	input  lsbu_pkg::lsbu_op_t  op,
	output logic               clearing,
	output logic               empty,
	input  logic               pop,
	output lsbu_pkg::lsbu_out_t result
);

	localparam int DEPTH = 2 ** lsbu_pkg::BUCKETS_LOG2;

	lsbu_pkg::lsbu_state_t state_q, state_d;
	logic [lsbu_pkg::BUCKETS_LOG2-1:0] clr_q;
	lsbu_pkg::lsbu_op_t    item_s1;
	lsbu_pkg::lsbu_entry_t mem [DEPTH];
	lsbu_pkg::lsbu_entry_t rd_q;
	lsbu_pkg::lsbu_entry_t wr_data;
	logic [lsbu_pkg::BUCKETS_LOG2-1:0] wr_addr;
	logic mem_we;
	logic mem_rd;
	logic done;
	logic out_v_q;
	lsbu_pkg::lsbu_out_t out_q;
	lsbu_pkg::lsbu_out_t res_d;

	logic [lsbu_pkg::COUNT_W-1:0] addend;
	logic [lsbu_pkg::COUNT_W:0]   sum;
	logic [lsbu_pkg::COUNT_W:0]   diff;
	logic [lsbu_pkg::COUNT_W-1:0] sat_sum;
	logic [lsbu_pkg::COUNT_W-1:0] abs_diff;
	lsbu_pkg::lsbu_entry_t        nxt;
	logic                         rep;

	assign clearing = (state_q == lsbu_pkg::ST_CLEAR);
	assign empty    = !out_v_q;
	assign result   = out_q;

	// bucket update
	always_comb begin
		addend   = (item_s1.kind == lsbu_pkg::KIND_UPDATE) ?
			lsbu_pkg::COUNT_W'(1) : item_s1.other_count;
		sum      = {1'b0, rd_q.count} + {1'b0, addend};
		diff     = {1'b0, rd_q.count} - {1'b0, addend};
		sat_sum  = sum[lsbu_pkg::COUNT_W] ? lsbu_pkg::COUNT_MAX : sum[lsbu_pkg::COUNT_W-1:0];
		abs_diff = addend - rd_q.count;
		nxt      = rd_q;
		rep      = 1'b0;
		if (item_s1.kind != lsbu_pkg::KIND_HOLD) begin
			if (!rd_q.occupied) begin
				nxt.occupied = 1'b1;
				nxt.key      = item_s1.key;
				nxt.count    = addend;
				rep          = 1'b1;
			end else if (rd_q.key == item_s1.key) begin
				nxt.count = sat_sum;
			end else if (diff[lsbu_pkg::COUNT_W]) begin
				nxt.key   = item_s1.key;
				nxt.count = abs_diff;
				rep       = 1'b1;
			end else begin
				nxt.count = diff[lsbu_pkg::COUNT_W-1:0];
			end
		end
		res_d.out_bucket   = lsbu_pkg::BUCKET_W'(item_s1.addr);
		res_d.out_key      = nxt.occupied ? nxt.key : '0;
		res_d.out_count    = nxt.occupied ? nxt.count : '0;
		res_d.out_occupied = nxt.occupied;
		res_d.key_replaced = rep;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= lsbu_pkg::ST_CLEAR;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		op_pop  = 1'b0;
		mem_rd  = 1'b0;
		mem_we  = 1'b0;
		done    = 1'b0;
		wr_addr = item_s1.addr;
		wr_data = nxt;
		case (state_q)
			lsbu_pkg::ST_CLEAR: begin
				mem_we  = 1'b1;
				wr_addr = clr_q;
				wr_data = '0;
				if (clr_q == {lsbu_pkg::BUCKETS_LOG2{1'b1}})
					state_d = lsbu_pkg::ST_IDLE;
			end
			lsbu_pkg::ST_IDLE: begin
				if (op_valid) begin
					op_pop  = 1'b1;
					mem_rd  = 1'b1;
					state_d = lsbu_pkg::ST_LOOK;
				end
			end
			lsbu_pkg::ST_LOOK: begin
				if (!out_v_q || pop) begin
					done    = 1'b1;
					mem_we  = 1'b1;
					state_d = lsbu_pkg::ST_IDLE;
				end
			end
			default: state_d = lsbu_pkg::ST_CLEAR;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q   <= '0;
			out_v_q <= 1'b0;
		end else begin
			if (clearing)
				clr_q <= clr_q + lsbu_pkg::BUCKETS_LOG2'(1);
			if (done)
				out_v_q <= 1'b1;
			else if (pop)
				out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (op_pop)
			item_s1 <= op;
		if (done)
			out_q <= res_d;
	end

	always_ff @(posedge clk) begin
		if (mem_we)
			mem[wr_addr] <= wr_data;
		if (mem_rd)
			rd_q <= mem[op.addr];
	end

	`ASSERT_IMPL(a_no_pop_clear, clearing, !op_pop, "queue popped during clear")
	`ASSERT_IMPL(a_empty_zero, out_v_q && !out_q.out_occupied,
		(out_q.out_key == '0) && (out_q.out_count == '0), "empty bucket with data")
	`ASSERT_IMPL(a_rep_occ, out_v_q && out_q.key_replaced, out_q.out_occupied,
		"key replaced but bucket empty")
	`ASSERT_CLK(a_out_from_look, $rose(out_v_q) |-> $past(state_q == lsbu_pkg::ST_LOOK),
		"result without lookup")

endmodule

>>> rtl/core/lossy_sketch_bucket_update.sv
// Flow: an accepted push is registered in the front queue, popped in ST_IDLE
// with a registered bucket read, then written back, its result registered in
// ST_LOOK once the output is free. One transaction at a time, set by the
// bucket memory read-modify-write (registered read, then compute and write
// back). Reset: arst_n clears control state, then a clear pass empties all
// 1024 buckets; full stays high during that pass.
module lossy_sketch_bucket_update (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  lsbu_pkg::lsbu_in_t  item,
	output logic               empty,
	input  logic               pop,
	output lsbu_pkg::lsbu_out_t result
);

	logic               clearing;
	logic               op_valid;
	logic               op_pop;
	lsbu_pkg::lsbu_op_t op;

	lsbu_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.item     (item),
		.hold     (clearing),
		.op_valid (op_valid),
		.op_pop   (op_pop),
		.op       (op)
	);

	lsbu_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.op_valid (op_valid),
		.op_pop   (op_pop),
		.op       (op),
		.clearing (clearing),
		.empty    (empty),
		.pop      (pop),
		.result   (result)
	);

endmodule

>>> tb/lossy_sketch_bucket_update_tb.sv
module lossy_sketch_bucket_update_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import lsbu_pkg::*;

	localparam logic OP_UPDATE = 1'b0;
	localparam logic OP_MERGE  = 1'b1;
	localparam int   NBUCKETS  = 1 << BUCKETS_LOG2;
	localparam int   HOT       = 8;
	localparam int   POOL      = 6;
	localparam int   PHASE_ITEMS   = 500;
	localparam int   STALL_LIMIT   = 4000;
	localparam int   DRAIN_CYCLES  = 16;
	localparam int   LONG_HOLD     = 300;

	class bucket_row_scoreboard;
		logic               occ_marks [NBUCKETS];
		logic [KEY_W-1:0]   keys      [NBUCKETS];
		logic [COUNT_W-1:0] counts    [NBUCKETS];
		lsbu_out_t          expected_entries[$];
		int                 mismatches;

		function new();
			for (int i = 0; i < NBUCKETS; i++) begin
				occ_marks[i] = 1'b0;
				keys[i]      = '0;
				counts[i]    = '0;
			end
			mismatches = 0;
		endfunction

		function logic [COUNT_W-1:0] sat_sum(logic [COUNT_W-1:0] a, logic [COUNT_W-1:0] b);
			logic [COUNT_W:0] s;
			s = {1'b0, a} + {1'b0, b};
			return s[COUNT_W] ? COUNT_MAX : s[COUNT_W-1:0];
		endfunction

		function lsbu_out_t predict_bucket(lsbu_in_t it);
			logic [BUCKETS_LOG2-1:0] b;
			logic [KEY_W-1:0]        k;
			logic [KEY_W-1:0]        sk;
			logic [COUNT_W-1:0]      sc;
			logic                    occ;
			logic                    repl;
			lsbu_out_t               r;
			b    = it.bucket[BUCKETS_LOG2-1:0];
			k    = it.key & KEY_MASK;
			occ  = occ_marks[b];
			sk   = keys[b];
			sc   = counts[b];
			repl = 1'b0;
			if (it.opcode == OP_UPDATE) begin
				if (!occ) begin
					occ = 1'b1; sk = k; sc = COUNT_W'(1); repl = 1'b1;
				end else if (sk == k) begin
					sc = sat_sum(sc, COUNT_W'(1));
				end else if (sc == '0) begin
					sk = k; sc = COUNT_W'(1); repl = 1'b1;
				end else begin
					sc = sc - COUNT_W'(1);
				end
			end else if (it.other_occupied) begin
				if (!occ) begin
					occ = 1'b1; sk = k; sc = it.other_count; repl = 1'b1;
				end else if (sk == k) begin
					sc = sat_sum(sc, it.other_count);
				end else if (it.other_count > sc) begin
					sc = it.other_count - sc; sk = k; repl = 1'b1;
				end else begin
					sc = sc - it.other_count;
				end
			end
			occ_marks[b] = occ;
			keys[b]      = sk;
			counts[b]    = sc;
			r.out_bucket   = BUCKET_W'(b);
			r.out_key      = occ ? sk : '0;
			r.out_count    = occ ? sc : '0;
			r.out_occupied = occ;
			r.key_replaced = repl;
			return r;
		endfunction

		function void note_input(lsbu_in_t it);
			expected_entries.push_back(predict_bucket(it));
		endfunction

		function void check_result(lsbu_out_t got);
			lsbu_out_t want;
			if (expected_entries.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: bucket %h key %h count %h occ %b repl %b",
						got.out_bucket, got.out_key, got.out_count,
						got.out_occupied, got.key_replaced);
				return;
			end
			want = expected_entries.pop_front();
			if (got.out_bucket !== want.out_bucket || got.out_key !== want.out_key ||
				got.out_count !== want.out_count || got.out_occupied !== want.out_occupied ||
				got.key_replaced !== want.key_replaced) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("mismatch exp: bucket %h key %h count %h occ %b repl %b",
						want.out_bucket, want.out_key, want.out_count,
						want.out_occupied, want.key_replaced);
					$display("         act: bucket %h key %h count %h occ %b repl %b",
						got.out_bucket, got.out_key, got.out_count,
						got.out_occupied, got.key_replaced);
				end
			end
		endfunction

		function int pending();
			return expected_entries.size();
		endfunction

		function void close_out();
			if (expected_entries.size() != 0) begin
				$display("%0d results never arrived", expected_entries.size());
				mismatches += expected_entries.size();
			end
		endfunction
	endclass

	logic      clk;
	logic      arst_n = 1'b0;
	logic      push   = 1'b0;
	logic      full;
	lsbu_in_t  item   = '0;
	logic      empty;
	logic      pop    = 1'b0;
	lsbu_out_t result;

	bucket_row_scoreboard sb = new();

	int send_idle_pct = 0;
	int stall_pct     = 0;
	int hold_req      = 0;
	int quiet_cycles  = 0;

	logic [BUCKET_W-1:0] hot_buckets[HOT];
	logic [KEY_W-1:0]    key_pool[POOL];

	lossy_sketch_bucket_update u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.item   (item),
		.empty  (empty),
		.pop    (pop),
		.result (result)
	);

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	always @(posedge clk) begin
		if (push && !full)
			sb.note_input(item);
		if (pop && !empty)
			sb.check_result(result);
	end

	// watchdog: no transaction on either side for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((push && !full) || (pop && !empty)) begin
				quiet_cycles <= 0;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
				if (quiet_cycles >= STALL_LIMIT) begin
					$display("timeout");
					$display("lossy_sketch_bucket_update regression: fail");
					$finish;
				end
			end
		end
	end

	initial begin
		int left;
		left = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req > 0) begin
				left = hold_req;
				hold_req = 0;
			end
			if (left > 0) begin
				left--;
				pop <= 1'b0;
			end else begin
				pop <= ($urandom_range(99) >= stall_pct);
			end
		end
	end

	function automatic lsbu_in_t mk(logic op, logic [BUCKET_W-1:0] b, logic [KEY_W-1:0] k,
		logic [COUNT_W-1:0] oc, logic oo);
		lsbu_in_t it;
		it.opcode         = op;
		it.bucket         = b;
		it.key            = k;
		it.other_count    = oc;
		it.other_occupied = oo;
		return it;
	endfunction

	function automatic lsbu_in_t rand_item();
		lsbu_in_t    it;
		int unsigned pick;
		it.opcode = ($urandom_range(99) < 70) ? OP_UPDATE : OP_MERGE;
		it.bucket = ($urandom_range(99) < 80) ? hot_buckets[$urandom_range(HOT - 1)]
			: BUCKET_W'($urandom);
		it.key = ($urandom_range(99) < 80) ? key_pool[$urandom_range(POOL - 1)]
			: {$urandom, $urandom};
		pick = $urandom_range(99);
		if (pick < 45)
			it.other_count = COUNT_W'($urandom_range(40));
		else if (pick < 75)
			it.other_count = COUNT_W'($urandom);
		else
			it.other_count = COUNT_MAX - COUNT_W'($urandom_range(3));
		it.other_occupied = ($urandom_range(99) < 85);
		return it;
	endfunction

	task automatic send_item(input lsbu_in_t it);
		while ($urandom_range(99) < send_idle_pct) begin
			push <= 1'b0;
			@(negedge clk);
		end
		push <= 1'b1;
		item <= it;
		@(posedge clk);
		while (full)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic drain();
		push <= 1'b0;
		@(negedge clk);
		while (sb.pending() != 0)
			@(negedge clk);
	endtask

	initial begin
		int           send_pct[4];
		int           recv_pct[4];
		logic [KEY_W-1:0] ka;
		logic [KEY_W-1:0] kb;
		logic [KEY_W-1:0] ones;
		send_pct = '{0, 53, 0, 11};
		recv_pct = '{0, 0, 53, 11};
		ka   = 64'h0123_4567_89ab_cdef;
		kb   = 64'hfedc_ba98_7654_3210;
		ones = '1;

		hot_buckets[0] = '0;
		hot_buckets[1] = '1;
		for (int i = 2; i < HOT; i++)
			hot_buckets[i] = BUCKET_W'($urandom);
		key_pool[0] = '0;
		key_pool[1] = ones;
		for (int i = 2; i < POOL; i++)
			key_pool[i] = {$urandom, $urandom};

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: place, match, mismatch down to zero, replace
		send_item(mk(OP_UPDATE, 10'd0, '0, '0, 1'b0));
		send_item(mk(OP_UPDATE, 10'd0, '0, COUNT_MAX, 1'b1));
		send_item(mk(OP_UPDATE, 10'd0, ones, '0, 1'b0));
		send_item(mk(OP_UPDATE, 10'd0, ones, '0, 1'b0));
		send_item(mk(OP_UPDATE, 10'd0, ones, '0, 1'b0));
		// merges: both empty, into empty, saturation, empty other, zero difference
		send_item(mk(OP_MERGE, 10'd1023, ones, COUNT_MAX, 1'b0));
		send_item(mk(OP_MERGE, 10'd1023, ones, COUNT_MAX, 1'b1));
		send_item(mk(OP_UPDATE, 10'd1023, ones, '0, 1'b0));
		send_item(mk(OP_MERGE, 10'd1023, ones, 31'd5, 1'b1));
		send_item(mk(OP_MERGE, 10'd1023, '0, 31'd7, 1'b0));
		send_item(mk(OP_MERGE, 10'd1023, '0, COUNT_MAX, 1'b1));
		send_item(mk(OP_UPDATE, 10'd1023, '0, '0, 1'b0));
		// merge add, subtract, negative difference takes the other key
		send_item(mk(OP_MERGE, 10'd5, ka, 31'd10, 1'b1));
		send_item(mk(OP_MERGE, 10'd5, ka, 31'd20, 1'b1));
		send_item(mk(OP_MERGE, 10'd5, kb, 31'd12, 1'b1));
		send_item(mk(OP_MERGE, 10'd5, kb, 31'd25, 1'b1));
		send_item(mk(OP_MERGE, 10'd5, ka, 31'd0, 1'b1));
		send_item(mk(OP_UPDATE, 10'd5, kb, COUNT_MAX, 1'b1));
		send_item(mk(OP_MERGE, 10'd6, kb, 31'd0, 1'b1));
		send_item(mk(OP_UPDATE, 10'd6, ka, '0, 1'b0));
		send_item(mk(OP_UPDATE, 10'h2aa, 64'h5555_5555_5555_5555, 31'h2aaa_aaaa, 1'b0));
		send_item(mk(OP_MERGE, 10'h155, 64'haaaa_aaaa_aaaa_aaaa, 31'h5555_5555, 1'b1));
		send_item(mk(OP_MERGE, 10'h2aa, 64'haaaa_aaaa_aaaa_aaaa, 31'h5555_5555, 1'b1));
		drain();

		for (int ph = 0; ph < 4; ph++) begin
			send_idle_pct = send_pct[ph];
			stall_pct     = recv_pct[ph];
			if (ph == 0)
				hold_req = LONG_HOLD;
			repeat (PHASE_ITEMS)
				send_item(rand_item());
			drain();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		sb.close_out();
		if (sb.mismatches == 0)
			$display("lossy_sketch_bucket_update regression: pass");
		else
			$display("lossy_sketch_bucket_update regression: fail");
		$finish;
	end

endmodule
